// File: rtl/core/ecbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error code blink sequencer package
// Shared types and fixed constants for the blink code generator.
// ----------------------------------------------------------------------------
package ecbs_pkg;

    localparam int TICKS_W = 16;
    localparam int COUNT_W = 4;
    localparam int CODE_W  = 8;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_ONCE    = 2'd1;
    localparam logic [OP_W-1:0] OP_FOREVER = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_TICKS  = 2'd2;

    // Register values after reset.
    localparam logic [TICKS_W-1:0] RST_BLINK_TICKS     = 16'd150;
    localparam logic [TICKS_W-1:0] RST_SHORT_GAP_TICKS = 16'd500;
    localparam logic [TICKS_W-1:0] RST_LONG_GAP_TICKS  = 16'd1150;

    typedef struct packed {
        logic pattern_done;
        logic busy_res;
        logic led_on;
    } result_t;

endpackage

// File: rtl/core/error_code_blink_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error code blink sequencer core
// Drives an error LED with a two-group blink code, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the operation (tick, start once, start
//   forever), tdata the 8-bit code. The upper nibble sets the blink count of
//   the first group, the lower nibble that of the second. Each tick transfer
//   advances the pattern by one tick; a start restarts it at once.
//   Output stream (m_*): one transfer per input transfer with the LED level,
//   the busy flag and the once-mode completion flag after that item.
//   Configuration channel (cfg_*): always ready; writes blink, short gap and
//   long gap durations in ticks. Write only while the block is idle.
// Timing:
//   Results are registered. One item is accepted per cycle while s_tready
//   is high; the next state comes from one decrement-and-compare on the
//   tick counter plus the phase decode.
//   A two-entry output stage (result register plus skid register) lets an
//   input transfer complete while a result waits; s_tready falls only when
//   both entries hold results during an output stall.
// Reset:
//   rst_n clears the pattern (LED off, idle) and loads the default durations
//   150, 500 and 1150 ticks. No clearing pass is needed.
// ----------------------------------------------------------------------------
module error_code_blink_sequencer_core
    import ecbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CODE_W-1:0]    s_tdata,   // [7:0] code
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] led_on, [1] busy_res,
                                            // [2] pattern_done, [7:3] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICKS_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_G1_ON  = 3'd1,
        PH_G1_OFF = 3'd2,
        PH_SHORT  = 3'd3,
        PH_G2_ON  = 3'd4,
        PH_G2_OFF = 3'd5,
        PH_LONG   = 3'd6
    } phase_t;

    logic [TICKS_W-1:0] blink_ticks_reg;
    logic [TICKS_W-1:0] short_gap_ticks_reg;
    logic [TICKS_W-1:0] long_gap_ticks_reg;

    phase_t             phase_reg, phase_next;
    logic [TICKS_W-1:0] ticks_left_reg, ticks_left_next;
    logic [COUNT_W-1:0] blinks_left_reg, blinks_left_next;
    logic [COUNT_W-1:0] first_count_reg, first_count_next;
    logic [COUNT_W-1:0] second_count_reg, second_count_next;
    logic               repeat_mode_reg, repeat_mode_next;
    logic               led_reg, led_next;
    logic               done_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    result_t result_next;

    logic               in_fire, out_pop;
    logic [TICKS_W-1:0] blink_eff, short_eff, long_eff;
    logic [COUNT_W-1:0] blinks_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b0, out_data_reg.pattern_done, out_data_reg.busy_res,
                        out_data_reg.led_on};

    // A zero duration counts as one tick.
    assign blink_eff  = (blink_ticks_reg == '0) ? TICKS_W'(1) : blink_ticks_reg;
    assign short_eff  = (short_gap_ticks_reg == '0) ? TICKS_W'(1) : short_gap_ticks_reg;
    assign long_eff   = (long_gap_ticks_reg == '0) ? TICKS_W'(1) : long_gap_ticks_reg;
    assign blinks_dec = blinks_left_reg - COUNT_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        ticks_left_next   = ticks_left_reg;
        blinks_left_next  = blinks_left_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        repeat_mode_next  = repeat_mode_reg;
        led_next          = led_reg;
        done_next         = 1'b0;

        case (s_tuser)
            OP_ONCE, OP_FOREVER:
            begin
                first_count_next  = s_tdata[7:4];
                second_count_next = s_tdata[3:0];
                repeat_mode_next  = (s_tuser == OP_FOREVER);
                if (s_tdata[7:4] != '0)
                begin
                    phase_next       = PH_G1_ON;
                    led_next         = 1'b1;
                    blinks_left_next = s_tdata[7:4];
                    ticks_left_next  = blink_eff;
                end
                else
                begin
                    phase_next      = PH_SHORT;
                    led_next        = 1'b0;
                    ticks_left_next = short_eff;
                end
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE && ticks_left_reg > TICKS_W'(1))
                begin
                    ticks_left_next = ticks_left_reg - TICKS_W'(1);
                end
                else if (phase_reg != PH_IDLE)
                begin
                    ticks_left_next = '0;
                    case (phase_reg)
                        PH_G1_ON, PH_G2_ON:
                        begin
                            phase_next      = (phase_reg == PH_G1_ON) ? PH_G1_OFF
                                                                       : PH_G2_OFF;
                            led_next        = 1'b0;
                            ticks_left_next = blink_eff;
                        end
                        PH_G1_OFF:
                        begin
                            blinks_left_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                phase_next      = PH_G1_ON;
                                led_next        = 1'b1;
                                ticks_left_next = blink_eff;
                            end
                            else
                            begin
                                phase_next      = PH_SHORT;
                                led_next        = 1'b0;
                                ticks_left_next = short_eff;
                            end
                        end
                        PH_SHORT:
                        begin
                            if (second_count_reg != '0)
                            begin
                                phase_next       = PH_G2_ON;
                                led_next         = 1'b1;
                                blinks_left_next = second_count_reg;
                                ticks_left_next  = blink_eff;
                            end
                            else
                            begin
                                phase_next      = PH_LONG;
                                led_next        = 1'b0;
                                ticks_left_next = long_eff;
                            end
                        end
                        PH_G2_OFF:
                        begin
                            blinks_left_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                phase_next      = PH_G2_ON;
                                led_next        = 1'b1;
                                ticks_left_next = blink_eff;
                            end
                            else
                            begin
                                phase_next      = PH_LONG;
                                led_next        = 1'b0;
                                ticks_left_next = long_eff;
                            end
                        end
                        PH_LONG:
                        begin
                            if (repeat_mode_reg)
                            begin
                                if (first_count_reg != '0)
                                begin
                                    phase_next       = PH_G1_ON;
                                    led_next         = 1'b1;
                                    blinks_left_next = first_count_reg;
                                    ticks_left_next  = blink_eff;
                                end
                                else
                                begin
                                    phase_next      = PH_SHORT;
                                    led_next        = 1'b0;
                                    ticks_left_next = short_eff;
                                end
                            end
                            else
                            begin
                                phase_next       = PH_IDLE;
                                led_next         = 1'b0;
                                blinks_left_next = '0;
                                done_next        = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused phase code falls back to idle.
                            phase_next = PH_IDLE;
                            led_next   = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                // The unused operation leaves the pattern untouched.
            end
        endcase

        result_next.led_on       = led_next;
        result_next.busy_res     = (phase_next != PH_IDLE);
        result_next.pattern_done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_ticks_reg     <= RST_BLINK_TICKS;
            short_gap_ticks_reg <= RST_SHORT_GAP_TICKS;
            long_gap_ticks_reg  <= RST_LONG_GAP_TICKS;
            phase_reg           <= PH_IDLE;
            ticks_left_reg      <= '0;
            blinks_left_reg     <= '0;
            first_count_reg     <= '0;
            second_count_reg    <= '0;
            repeat_mode_reg     <= 1'b0;
            led_reg             <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
            out_data_reg        <= '0;
            skid_data_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BLINK_TICKS:     blink_ticks_reg     <= cfg_data;
                    CFG_SHORT_GAP_TICKS: short_gap_ticks_reg <= cfg_data;
                    CFG_LONG_GAP_TICKS:  long_gap_ticks_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                phase_reg        <= phase_next;
                ticks_left_reg   <= ticks_left_next;
                blinks_left_reg  <= blinks_left_next;
                first_count_reg  <= first_count_next;
                second_count_reg <= second_count_next;
                repeat_mode_reg  <= repeat_mode_next;
                led_reg          <= led_next;
            end

            // The result register drains first; the skid register catches a
            // transfer that arrives while the result register is stalled.
            if (!out_valid_reg || out_pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                    out_data_reg  <= result_next;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= result_next;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_led_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> (phase_reg == PH_G1_ON || phase_reg == PH_G2_ON))
        else $error("LED lit outside an on phase");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.pattern_done) |-> !out_data_reg.busy_res)
        else $error("pattern finished while still reported busy");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == OP_TICK && phase_reg == PH_IDLE)
        |=> (phase_reg == PH_IDLE && !led_reg))
        else $error("tick left the idle phase");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

endmodule

// File: bench/error_code_blink_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error code blink sequencer core testbench
// Drives tick and start transfers in random bursts against a stalling
// receiver, and checks each result against a directed row's value or a
// cycle-free model of the two-group blink pattern. A short directed table
// comes first, then random start-and-tick sequences under a series of
// duration settings.
module error_code_blink_sequencer_core_tb;
    import ecbs_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES   = 4;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int CYCLE_LIMIT     = 400000;

    localparam result_t R_IDLE = '{pattern_done: 1'b0, busy_res: 1'b0, led_on: 1'b0};
    localparam result_t R_LIT  = '{pattern_done: 1'b0, busy_res: 1'b1, led_on: 1'b1};
    localparam result_t R_DARK = '{pattern_done: 1'b0, busy_res: 1'b1, led_on: 1'b0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_ON,
        ST_MOD_OFF,
        ST_SHORT_GAP,
        ST_SUB_ON,
        ST_SUB_OFF,
        ST_LONG_GAP
    } blink_phase_t;

    typedef struct packed {
        logic           is_cfg;
        logic [1:0]     sel;     // operation, or register index
        logic [15:0]    val;     // code, or register value
        logic           typed;   // expected result given in the row
        result_t        want;
    } dir_row_t;

    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;
    localparam logic PRED     = 1'b0;
    localparam logic CHK      = 1'b1;
    localparam int   N_DIRECTED = 29;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_ITEM, OP_TICK,             16'h0000, CHK,  R_IDLE},
        '{ROW_ITEM, OP_UNUSED,           16'h00FF, CHK,  R_IDLE},
        '{ROW_ITEM, OP_ONCE,             16'h0021, CHK,  R_LIT},
        '{ROW_ITEM, OP_TICK,             16'h00A5, PRED, R_IDLE},
        '{ROW_ITEM, OP_UNUSED,           16'h0000, CHK,  R_LIT},
        '{ROW_ITEM, OP_FOREVER,          16'h0000, CHK,  R_DARK},
        '{ROW_ITEM, OP_TICK,             16'h005A, PRED, R_IDLE},
        '{ROW_ITEM, OP_ONCE,             16'h000F, CHK,  R_DARK},
        '{ROW_ITEM, OP_ONCE,             16'h00F0, CHK,  R_LIT},
        '{ROW_CFG,  CFG_BLINK_TICKS,     16'h0000, PRED, R_IDLE},
        '{ROW_CFG,  CFG_SHORT_GAP_TICKS, 16'h0000, PRED, R_IDLE},
        '{ROW_CFG,  CFG_LONG_GAP_TICKS,  16'h0000, PRED, R_IDLE},
        '{ROW_CFG,  CFG_UNUSED,          16'hFFFF, PRED, R_IDLE},
        '{ROW_ITEM, OP_ONCE,             16'h0011, CHK,  R_LIT},
        '{ROW_ITEM, OP_TICK,             16'h0000, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h00FF, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h0033, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h00CC, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h0055, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h00AA, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h0000, CHK,  R_IDLE},
        '{ROW_CFG,  CFG_BLINK_TICKS,     16'hFFFF, PRED, R_IDLE},
        '{ROW_CFG,  CFG_SHORT_GAP_TICKS, 16'hFFFF, PRED, R_IDLE},
        '{ROW_CFG,  CFG_LONG_GAP_TICKS,  16'hFFFF, PRED, R_IDLE},
        '{ROW_ITEM, OP_FOREVER,          16'h00FF, CHK,  R_LIT},
        '{ROW_ITEM, OP_TICK,             16'h0000, PRED, R_IDLE},
        '{ROW_ITEM, OP_TICK,             16'h00FF, PRED, R_IDLE},
        '{ROW_ITEM, OP_ONCE,             16'h0000, CHK,  R_DARK},
        '{ROW_ITEM, OP_TICK,             16'h0000, PRED, R_IDLE}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CODE_W-1:0]    s_tdata   = '0;   // [7:0] code
    logic [OP_W-1:0]      s_tuser   = '0;   // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [0] led_on, [1] busy_res,
                                            // [2] pattern_done, [7:3] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICKS_W-1:0]   cfg_data  = '0;

    // Model copy of the durations and the pattern state.
    logic [TICKS_W-1:0] dur_blink = RST_BLINK_TICKS;
    logic [TICKS_W-1:0] dur_short = RST_SHORT_GAP_TICKS;
    logic [TICKS_W-1:0] dur_long  = RST_LONG_GAP_TICKS;
    blink_phase_t       seq_phase = ST_IDLE;
    logic [TICKS_W-1:0] ticks_left  = '0;
    logic [COUNT_W-1:0] blinks_left = '0;
    logic [COUNT_W-1:0] grp_mod     = '0;
    logic [COUNT_W-1:0] grp_sub     = '0;
    logic               repeat_on   = 1'b0;
    logic               lamp        = 1'b0;

    result_t status_due [$];
    int      mismatches  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    int      rx_mode     = 0;
    int      rx_span     = 0;
    int      rx_count    = 0;
    string   field_name [3] = '{"led_on", "busy_res", "pattern_done"};

    error_code_blink_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void light_for(blink_phase_t nxt);
        seq_phase  = nxt;
        lamp       = 1'b1;
        ticks_left = (dur_blink == '0) ? 16'd1 : dur_blink;
    endfunction

    function automatic void dark_for(blink_phase_t nxt, logic [TICKS_W-1:0] dur);
        seq_phase  = nxt;
        lamp       = 1'b0;
        ticks_left = (dur == '0) ? 16'd1 : dur;
    endfunction

    // An empty first group goes straight to the short gap.
    function automatic void start_module_group();
        if (grp_mod != '0)
        begin
            blinks_left = grp_mod;
            light_for(ST_MOD_ON);
        end
        else
            dark_for(ST_SHORT_GAP, dur_short);
    endfunction

    function automatic result_t blink_predict(logic [OP_W-1:0] op, logic [CODE_W-1:0] code);
        result_t r;
        logic    fin;
        fin = 1'b0;
        if (op == OP_ONCE || op == OP_FOREVER)
        begin
            grp_mod   = code[7:4];
            grp_sub   = code[3:0];
            repeat_on = (op == OP_FOREVER);
            start_module_group();
        end
        else if (op == OP_TICK && seq_phase != ST_IDLE)
        begin
            if (ticks_left > 16'd1)
                ticks_left = ticks_left - 16'd1;
            else
            begin
                ticks_left = '0;
                case (seq_phase)
                    ST_MOD_ON:  dark_for(ST_MOD_OFF, dur_blink);
                    ST_MOD_OFF:
                    begin
                        blinks_left = blinks_left - 4'd1;
                        if (blinks_left != '0)
                            light_for(ST_MOD_ON);
                        else
                            dark_for(ST_SHORT_GAP, dur_short);
                    end
                    ST_SHORT_GAP:
                    begin
                        if (grp_sub != '0)
                        begin
                            blinks_left = grp_sub;
                            light_for(ST_SUB_ON);
                        end
                        else
                            dark_for(ST_LONG_GAP, dur_long);
                    end
                    ST_SUB_ON:  dark_for(ST_SUB_OFF, dur_blink);
                    ST_SUB_OFF:
                    begin
                        blinks_left = blinks_left - 4'd1;
                        if (blinks_left != '0)
                            light_for(ST_SUB_ON);
                        else
                            dark_for(ST_LONG_GAP, dur_long);
                    end
                    ST_LONG_GAP:
                    begin
                        if (repeat_on)
                            start_module_group();
                        else
                        begin
                            seq_phase   = ST_IDLE;
                            lamp        = 1'b0;
                            blinks_left = '0;
                            fin         = 1'b1;
                        end
                    end
                    default:
                    begin
                        seq_phase = ST_IDLE;
                        lamp      = 1'b0;
                    end
                endcase
            end
        end
        r.led_on       = lamp;
        r.busy_res     = (seq_phase != ST_IDLE);
        r.pattern_done = fin;
        return r;
    endfunction

    // Sends one item, opening a random gap whenever a burst runs out.
    task automatic send_item(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                             logic typed, result_t want);
        result_t predicted;
        int      gap;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = blink_predict(op, code);
        status_due.push_back(typed ? want : predicted);
    endtask

    // Leaves cfg_valid high so back-to-back writes follow without a gap.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICKS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BLINK_TICKS:     dur_blink = val;
            CFG_SHORT_GAP_TICKS: dur_short = val;
            CFG_LONG_GAP_TICKS:  dur_long  = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: switches between free flow, random, periodic and long stalls.
    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(20, 200);
        end
        rx_span--;
        rx_count++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_count % 8) >= 3;
            default: m_tready <= (rx_count % 16) == 0;
        endcase
    end

    always @(posedge clk)
    begin : check_result
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[2:0];
            if (status_due.size() == 0)
            begin
                $display("%0t: result transfer %b with nothing expected", $time, got);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                for (int b = 0; b < 3; b++)
                begin
                    if (got[b] !== want[b])
                    begin
                        $display("%0t: %s expected %b actual %b", $time, field_name[b],
                                 want[b], got[b]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("error_code_blink_sequencer_core test failed");
        $finish;
    end

    initial
    begin
        logic              prev_item;
        int                counted;
        int                n_ticks;
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        prev_item = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].is_cfg)
            begin
                if (prev_item)
                    drain();
                write_reg(DIRECTED[i].sel, DIRECTED[i].val);
                prev_item = 1'b0;
            end
            else
            begin
                send_item(DIRECTED[i].sel, DIRECTED[i].val[7:0], DIRECTED[i].typed,
                          DIRECTED[i].want);
                prev_item = 1'b1;
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            // Mostly short durations so that whole patterns run to the end.
            if (p == 3)
            begin
                write_reg(CFG_BLINK_TICKS, 16'($urandom));
                write_reg(CFG_SHORT_GAP_TICKS, 16'($urandom));
                write_reg(CFG_LONG_GAP_TICKS, 16'($urandom));
            end
            else if (p == 7)
            begin
                write_reg(CFG_BLINK_TICKS, 16'd1);
                write_reg(CFG_SHORT_GAP_TICKS, 16'd1);
                write_reg(CFG_LONG_GAP_TICKS, 16'd1);
            end
            else
            begin
                write_reg(CFG_BLINK_TICKS, 16'($urandom_range(0, 3)));
                write_reg(CFG_SHORT_GAP_TICKS, 16'($urandom_range(0, 6)));
                write_reg(CFG_LONG_GAP_TICKS, 16'($urandom_range(0, 6)));
            end

            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                op = ($urandom_range(0, 1) != 0) ? OP_FOREVER : OP_ONCE;
                if ($urandom_range(0, 9) < 7)
                    code = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
                else
                    code = 8'($urandom);
                send_item(op, code, PRED, R_IDLE);
                counted++;
                // A short run of ticks leaves the pattern to be cut off by
                // the next start.
                n_ticks = $urandom_range(1, 60);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 29) == 0)
                        send_item(OP_UNUSED, 8'($urandom), PRED, R_IDLE);
                    else
                    begin
                        send_item(OP_TICK, 8'($urandom), PRED, R_IDLE);
                        counted++;
                    end
                end
            end
        end

        drain();
        if (mismatches == 0 && status_due.size() == 0)
            $display("error_code_blink_sequencer_core test passed");
        else
            $display("error_code_blink_sequencer_core test failed");
        $finish;
    end

endmodule
